>>> rtl/mlfq_pkg.sv
// shared types and codes for the multilevel feedback scheduler
package mlfq_pkg;

  localparam int MAX_PROCESSES    = 16;
  localparam int MAX_LEVELS       = 8;
  localparam int MAX_INSTRUCTIONS = 16;

  localparam logic [1:0] EV_RUN    = 2'd0;
  localparam logic [1:0] EV_QUEUED = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;
  localparam logic [1:0] EV_REJECT = 2'd3;

  localparam logic MODE_SUBMIT   = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [3:0] process_id;
    logic [4:0] instruction_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] done_process;
    logic [3:0] done_instruction;
    logic [2:0] new_level;
    logic       process_finished;
    logic       next_valid;
    logic [3:0] next_process;
  } res_t;

endpackage

>>> rtl/mlfq_front.sv
// command intake: two-entry queue between the stream input and the scheduler core
module mlfq_front import mlfq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic cmd_valid,
  input  logic cmd_take,
  output cmd_t cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/mlfq_core.sv
// scheduler core: per-process tables, level queues and result register
module mlfq_core import mlfq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] levels_in_use,
  input  logic       cmd_valid,
  output logic       cmd_take,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int FW = $clog2(MAX_PROCESSES + 1);
  localparam int CW = $clog2(MAX_INSTRUCTIONS + 1);
  localparam int MW = (MAX_LEVELS * MAX_PROCESSES > 1) ?
                      $clog2(MAX_LEVELS * MAX_PROCESSES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} state_t;

  state_t            state;
  logic              running_valid;
  logic [PW-1:0]     running_process;
  logic [LW-1:0]     process_level [MAX_PROCESSES];
  logic [CW-1:0]     remaining_count [MAX_PROCESSES];
  logic [CW-1:0]     executed_count [MAX_PROCESSES];
  logic [PW-1:0]     queue_mem [MAX_LEVELS * MAX_PROCESSES];
  logic [PW-1:0]     head [MAX_LEVELS];
  logic [FW-1:0]     fill [MAX_LEVELS];
  logic [PW-1:0]     mem_rdata;
  cmd_t              cur;

  // lowest-numbered (highest-priority) nonempty level, searched over all levels
  logic              got;
  logic [LW-1:0]     best;
  always_comb begin
    got  = 1'b0;
    best = '0;
    for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
      if (fill[l] != '0) begin
        got  = 1'b1;
        best = LW'(l);
      end
    end
  end

  logic [3:0]    used;
  logic [LW-1:0] lowest;
  always_comb begin
    used = levels_in_use;
    if (used == 4'd0) used = 4'd1;
    if (32'(used) > MAX_LEVELS) used = 4'(MAX_LEVELS);
    lowest = LW'(used - 4'd1);
  end

  logic          pid_ok;
  logic [PW-1:0] pid;
  assign pid_ok   = 32'(cur.process_id) < MAX_PROCESSES;
  assign pid      = PW'(cur.process_id);
  assign cmd_take = (state == S_IDLE);

  logic [PW-1:0] rp;
  logic [LW-1:0] lvl;
  logic [CW-1:0] rem;
  logic          fin;
  always_comb begin
    rp  = running_process;
    lvl = process_level[rp];
    if (lvl < lowest) lvl = lvl + 1'b1;
    rem = remaining_count[rp];
    if (rem != '0) rem = rem - 1'b1;
    fin = (rem == '0);
  end

  function automatic logic [MW-1:0] addr(input logic [LW-1:0] l, input logic [PW-1:0] s);
    addr = MW'(32'(l) * MAX_PROCESSES + 32'(s));
  endfunction

  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] h, input logic [FW-1:0] f);
    logic [31:0] s;
    s = 32'(h) + 32'(f);
    if (s >= MAX_PROCESSES) s = s - MAX_PROCESSES;
    slot_of = PW'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      running_valid   <= 1'b0;
      running_process <= '0;
      res_valid       <= 1'b0;
      for (int i = 0; i < MAX_PROCESSES; i++) remaining_count[i] <= '0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
        head[l] <= '0;
        fill[l] <= '0;
      end
    end else begin
      if (res_valid && res_ready && state != S_WRITE) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_take) begin
            cur   <= cmd;
            state <= S_READ;
          end
        end
        S_READ: begin
          // queue head read into mem_rdata, result formed in S_WRITE
          mem_rdata <= queue_mem[addr(best, head[best])];
          state     <= S_WRITE;
        end
        S_WRITE: begin
          // wait here while the previous result is still held
          if (!res_valid || res_ready) begin
            state     <= S_IDLE;
            res_valid <= 1'b1;
            res.done_instruction <= '0;
            res.new_level        <= '0;
            res.process_finished <= 1'b0;
            if (cur.mode == MODE_SUBMIT) begin
              res.done_process <= cur.process_id;
              if (!pid_ok || cur.instruction_count == '0 ||
                  32'(cur.instruction_count) > MAX_INSTRUCTIONS ||
                  remaining_count[pid] != '0) begin
                res.event_kind   <= EV_REJECT;
                res.next_valid   <= running_valid;
                res.next_process <= running_valid ? 4'(running_process) : 4'd0;
              end else begin
                process_level[pid]   <= '0;
                remaining_count[pid] <= CW'(cur.instruction_count);
                executed_count[pid]  <= '0;
                res.next_valid       <= 1'b1;
                if (!running_valid) begin
                  running_valid    <= 1'b1;
                  running_process  <= pid;
                  res.event_kind   <= EV_RUN;
                  res.next_process <= 4'(pid);
                end else begin
                  res.event_kind   <= EV_QUEUED;
                  res.next_process <= 4'(running_process);
                  if (32'(fill[0]) < MAX_PROCESSES) begin
                    queue_mem[addr('0, slot_of(head[0], fill[0]))] <= pid;
                    fill[0] <= fill[0] + 1'b1;
                  end
                end
              end
            end else if (!running_valid) begin
              res.event_kind   <= EV_REJECT;
              res.done_process <= 4'd0;
              res.next_valid   <= 1'b0;
              res.next_process <= 4'd0;
            end else begin
              executed_count[rp]   <= executed_count[rp] + 1'b1;
              remaining_count[rp]  <= rem;
              process_level[rp]    <= lvl;
              res.event_kind       <= EV_DONE;
              res.done_process     <= 4'(rp);
              res.done_instruction <= 4'(executed_count[rp]);
              res.new_level        <= 3'(lvl);
              res.process_finished <= fin;
              if (got) begin
                head[best] <= slot_of(head[best], FW'(1));
                running_process  <= mem_rdata;
                res.next_valid   <= 1'b1;
                res.next_process <= 4'(mem_rdata);
                if (!fin) begin
                  if (lvl == best) begin
                    // pop and push on one queue: fill unchanged
                    queue_mem[addr(lvl, slot_of(head[lvl], fill[lvl]))] <= rp;
                  end else begin
                    fill[best] <= fill[best] - 1'b1;
                    if (32'(fill[lvl]) < MAX_PROCESSES) begin
                      queue_mem[addr(lvl, slot_of(head[lvl], fill[lvl]))] <= rp;
                      fill[lvl] <= fill[lvl] + 1'b1;
                    end
                  end
                end else begin
                  fill[best] <= fill[best] - 1'b1;
                end
              end else if (!fin) begin
                res.next_valid   <= 1'b1;
                res.next_process <= 4'(rp);
              end else begin
                running_valid    <= 1'b0;
                running_process  <= '0;
                res.next_valid   <= 1'b0;
                res.next_process <= 4'd0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/multilevel_feedback_scheduler.sv
// top level of the multilevel feedback scheduler
// Single-processor multilevel feedback queue scheduler. Each input item is a
// submit (mode 0) or a completion of the running instruction (mode 1) and
// yields exactly one result item. A two-entry intake queue takes items while
// the core works; the core handles each item in three steps (latch, queue-memory
// read of the best level's head, write-back with the result register) and
// finishes one item before it takes the next. The core takes the next item
// while a result waits and holds in write-back until that result is taken;
// the intake keeps filling meanwhile. levels_in_use may be written only while
// the block is idle; it takes effect on the next completion.
module multilevel_feedback_scheduler import mlfq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [0:0]  s_tuser,  // mode
  input  logic [15:0] s_tdata,  // process_id[3:0], instruction_count[8:4], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,  // event_kind
  output logic [23:0] m_tdata   // done_process, done_instruction, new_level,
                                // process_finished, next_valid, next_process, zero fill
);

  logic [3:0] levels_in_use;
  cmd_t       in_cmd;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_take;
  res_t       res;

  // configuration register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= 4'd5;
    end else if (cfg_valid) begin
      levels_in_use <= cfg_data;
    end
  end

  assign in_cmd.mode              = s_tuser[0];
  assign in_cmd.process_id        = s_tdata[3:0];
  assign in_cmd.instruction_count = s_tdata[8:4];

  mlfq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  mlfq_core u_core (
    .clk           (clk),
    .rst           (rst),
    .levels_in_use (levels_in_use),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take),
    .cmd           (cmd),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .res           (res)
  );

  // result packing, lowest field first
  assign m_tuser = res.event_kind;
  assign m_tdata = {7'd0, res.next_process, res.next_valid, res.process_finished,
                    res.new_level, res.done_instruction, res.done_process};

  // a waiting result holds steady
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a completion that leaves the processor idle has finished its process
  a_rej: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_DONE |-> m_tdata[12] || m_tdata[11])
    else $error("completion left processor idle with work pending");

  // an accepted submit always leaves a process running
  a_sub: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == EV_RUN || m_tuser == EV_QUEUED) |-> m_tdata[12])
    else $error("submit left processor idle");

endmodule
